>>> sv/spq_pkg.sv
// Shared constants, entry type and status codes of the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FILL_W   = 5;

  localparam logic [1:0] ST_PUSHED    = 2'd0;
  localparam logic [1:0] ST_POPPED    = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: sequencer, compare unit, ring storage and result register.
// Underflow, overflow and push into empty go straight to the emit step; pop reads the head
// entry (read, compare, emit); push runs a read-compare-write loop from the tail over the
// entry RAM, moving entries with a larger priority back one slot, then writing the new one.
// One word at a time: the next word is taken once the result is in the output register.
// Reset empties the queue at once (count and head cleared); the RAM is left as it is.
module sorted_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   payload_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [spq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic signed [spq_pkg::DATA_W-1:0]   out_payload_o,
  output logic [spq_pkg::FILL_W-1:0]          fill_level_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [spq_pkg::CNT_W-1:0] CAP_CNT = spq_pkg::CNT_W'(spq_pkg::CAPACITY);
  localparam logic [spq_pkg::IDX_W:0]   CAP_EXT = (spq_pkg::IDX_W + 1)'(spq_pkg::CAPACITY);

  function automatic logic [spq_pkg::IDX_W-1:0] phys(
    input logic [spq_pkg::IDX_W-1:0] head,
    input logic [spq_pkg::IDX_W-1:0] off
  );
    logic [spq_pkg::IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[spq_pkg::IDX_W-1:0];
  endfunction

  logic [2:0]                     state_q, state_d;
  logic [spq_pkg::CNT_W-1:0]      count_q, count_d;
  logic [spq_pkg::IDX_W-1:0]      head_q, head_d;
  logic [spq_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                           op_q, op_d;
  spq_pkg::entry_t                new_q, new_d;
  logic [1:0]                     res_status_q, res_status_d;
  spq_pkg::entry_t                res_entry_q, res_entry_d;
  logic                           out_valid_q, out_valid_d;
  logic [1:0]                     out_status_q, out_status_d;
  spq_pkg::entry_t                out_entry_q, out_entry_d;
  logic [spq_pkg::FILL_W-1:0]     out_fill_q, out_fill_d;

  logic                           ram_we;
  logic [spq_pkg::IDX_W-1:0]      ram_waddr;
  spq_pkg::entry_t                ram_wdata;
  logic [spq_pkg::IDX_W-1:0]      ram_raddr;
  spq_pkg::entry_t                ram_rdata;

  logic                           in_accept;
  logic                           out_free;
  logic                           moves_back;
  logic [spq_pkg::CNT_W+spq_pkg::FILL_W-1:0] fill_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign moves_back = ($signed(ram_rdata.prio) > $signed(new_q.prio));
  assign fill_wide  = (spq_pkg::CNT_W + spq_pkg::FILL_W)'(count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    idx_d        = idx_q;
    op_d         = op_q;
    new_d        = new_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_fill_d   = out_fill_q;
    ram_we       = 1'b0;
    ram_waddr    = head_q;
    ram_wdata    = new_q;
    ram_raddr    = phys(head_q, idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d        = operation_i;
          new_d.prio  = priority_req_i;
          new_d.data  = payload_i;
          res_entry_d = '0;
          if (operation_i) begin
            if (count_q == '0) begin
              res_status_d = spq_pkg::ST_UNDERFLOW;
              state_d      = S_EMIT;
            end else begin
              idx_d   = '0;
              state_d = S_RD;
            end
          end else if (count_q == CAP_CNT) begin
            res_status_d = spq_pkg::ST_OVERFLOW;
            state_d      = S_EMIT;
          end else if (count_q == '0) begin
            ram_we          = 1'b1;
            ram_waddr       = head_q;
            ram_wdata.prio  = priority_req_i;
            ram_wdata.data  = payload_i;
            count_d         = count_q + 1'b1;
            res_status_d    = spq_pkg::ST_PUSHED;
            state_d         = S_EMIT;
          end else begin
            idx_d   = spq_pkg::IDX_W'(count_q - 1'b1);
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (op_q) begin
          res_entry_d  = ram_rdata;
          res_status_d = spq_pkg::ST_POPPED;
          head_d       = phys(head_q, spq_pkg::IDX_W'(1));
          count_d      = count_q - 1'b1;
          state_d      = S_EMIT;
        end else if (moves_back) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, idx_q + 1'b1);
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_INS;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_RD;
          end
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = phys(head_q, idx_q + 1'b1);
          ram_wdata    = new_q;
          count_d      = count_q + 1'b1;
          res_status_d = spq_pkg::ST_PUSHED;
          state_d      = S_EMIT;
        end
      end
      S_INS: begin
        ram_we       = 1'b1;
        ram_waddr    = head_q;
        ram_wdata    = new_q;
        count_d      = count_q + 1'b1;
        res_status_d = spq_pkg::ST_PUSHED;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_fill_d   = fill_wide[spq_pkg::FILL_W-1:0];
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    op_q         <= op_d;
    new_q        <= new_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_fill_q   <= out_fill_d;
  end

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_priority_o = out_entry_q.prio;
  assign out_payload_o  = out_entry_q.data;
  assign fill_level_o   = out_fill_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != S_IDLE))
    else $error("sequencer idle after accepted word");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result word raised outside emit step");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_status_q == spq_pkg::ST_UNDERFLOW) |-> (count_q == '0))
    else $error("underflow reported on non-empty queue");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_accept) |-> !ram_we)
    else $error("entry write without an operation in progress");

endmodule
